// ===== hw/rtl/acfm_pkg.sv =====
// Package for the arithmetic coder frequency model; also its divider types.
// Holds widths, action codes and the sequencer state type; no dependencies.
`default_nettype none
package acfm_pkg;
    localparam int SYMBOLS    = 256;
    localparam int SYM_BITS   = 8;
    localparam int COUNT_BITS = 31;
    localparam int WORD_BITS  = 32;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_DECODE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OWN,
        ST_RD_PREV,
        ST_CHECK,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DEC_SCALE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] dividend;
        logic [WORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/acfm_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on acfm_pkg. A zero divisor gives an all-ones quotient.
`default_nettype none
module acfm_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire acfm_pkg::div_req_t req,
    output acfm_pkg::div_rsp_t     rsp
);
    import acfm_pkg::*;

    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WORD_BITS-1]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_BITS])
            begin
                rem_next = trial[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WORD_BITS-2:0], quo_reg[WORD_BITS-1]};
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg) else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 6'd0) else $error("divider count left over");
endmodule
`default_nettype wire

// ===== hw/rtl/arith_coder_freq_model.sv =====
// Top level of the arithmetic coder cumulative frequency model.
// Depends on acfm_pkg and acfm_divider; holds the count memory and the sequencer.
//
// Raise start for one cycle while busy is low to issue a request; busy then
// stays high until the single result appears on the output ports for exactly
// one cycle, marked by done. The receiver cannot stall the block, so results
// must be captured on the done cycle. The cumulative counts live in a
// 256-entry single-port memory with a registered read, so every step is
// bounded by that port: an accepted update spends a read state and a write
// state on each entry from the symbol to the end of the table, a clear sweeps
// all 256 entries, encode takes a serial division plus two multiplies, and
// decode one or two serial divisions (the second is skipped on a zero scale
// factor) plus eight binary search probes, each a read and a compare state.
// Immediately after reset a sweep clears all 256 entries with busy high.
// A zero scale factor sets divide_error; decode then searches for an
// all-ones scaled value.
`default_nettype none
module arith_coder_freq_model (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  symbol,
    input  wire logic signed [31:0] delta,
    input  wire logic [31:0] range_low,
    input  wire logic [31:0] range_high,
    input  wire logic [31:0] code_value,
    output logic             done,
    output logic             accepted,
    output logic [31:0]      lower_bound,
    output logic [31:0]      upper_bound,
    output logic [7:0]       decoded_symbol,
    output logic [30:0]      symbol_count,
    output logic [30:0]      total_count,
    output logic             divide_error
);
    import acfm_pkg::*;

    // Count memory: one port, registered read.
    logic [COUNT_BITS-1:0] mem [SYMBOLS];
    logic                  mem_we;
    logic [SYM_BITS-1:0]   mem_addr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    state_t state_reg, state_next;

    // Latched request.
    action_t              act_reg, act_next;
    logic [SYM_BITS-1:0]  sym_reg, sym_next;
    logic signed [31:0]   dlt_reg, dlt_next;
    logic [31:0]          lo_reg, lo_next;
    logic [31:0]          hi_reg, hi_next;
    logic [31:0]          code_reg, code_next;

    // Working values.
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] own_cum_reg, own_cum_next;
    logic [COUNT_BITS-1:0] prev_reg, prev_next;
    logic [31:0]           scale_reg, scale_next;
    logic [31:0]           scaled_reg, scaled_next;
    logic [SYM_BITS:0]     idx_reg, idx_next;
    logic [SYM_BITS:0]     up_reg, up_next;
    logic signed [SYM_BITS+1:0] low_reg, low_next;
    logic                  pass_reg, pass_next;
    logic [31:0]           lb_reg, lb_next;
    logic [31:0]           ub_reg, ub_next;

    // Result registers.
    logic        done_reg, done_next;
    logic        acc_reg, acc_next;
    logic [31:0] olb_reg, olb_next;
    logic [31:0] oub_reg, oub_next;
    logic [7:0]  osym_reg, osym_next;
    logic [30:0] ocnt_reg, ocnt_next;
    logic [30:0] otot_reg, otot_next;
    logic        oerr_reg, oerr_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    acfm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared 32x32 multiplier, low word only; result registered in lb/ub.
    logic [31:0] mul_a, mul_p;
    assign mul_p = mul_a * scale_reg;

    logic signed [33:0]    new_total;
    logic signed [33:0]    own_plus;
    logic [COUNT_BITS-1:0] own_cnt;
    logic [SYM_BITS:0]     mid;
    logic signed [SYM_BITS+1:0] mid_s;

    assign own_cnt   = own_cum_reg - prev_reg;
    assign new_total = $signed({3'b000, total_reg}) + 34'(dlt_reg);
    assign own_plus  = $signed({3'b000, own_cnt}) + 34'(dlt_reg);
    assign mid_s     = ($signed({1'b0, up_reg}) + low_reg) >>> 1;
    assign mid       = mid_s[SYM_BITS:0];

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        sym_next     = sym_reg;
        dlt_next     = dlt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        code_next    = code_reg;
        total_next   = total_reg;
        own_cum_next = own_cum_reg;
        prev_next    = prev_reg;
        scale_next   = scale_reg;
        scaled_next  = scaled_reg;
        idx_next     = idx_reg;
        up_next      = up_reg;
        low_next     = low_reg;
        pass_next    = pass_reg;
        lb_next      = lb_reg;
        ub_next      = ub_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        olb_next     = olb_reg;
        oub_next     = oub_reg;
        osym_next    = osym_reg;
        ocnt_next    = ocnt_reg;
        otot_next    = otot_reg;
        oerr_next    = oerr_reg;
        mem_we       = 1'b0;
        mem_addr     = sym_reg;
        mem_wdata    = '0;
        div_req      = '0;
        mul_a        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // No request is taken on the cycle that carries a result.
                if (start && !done_reg)
                begin
                    act_next  = action_t'(action);
                    sym_next  = symbol;
                    dlt_next  = delta;
                    lo_next   = range_low;
                    hi_next   = range_high;
                    code_next = code_value;
                    pass_next = 1'b0;
                    mem_addr  = symbol;
                    if (action_t'(action) == ACT_CLEAR)
                    begin
                        idx_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                        state_next = ST_RD_OWN;
                end
            end
            ST_RD_OWN:
            begin
                // Read of cum[sym] issued last cycle; now issue cum[sym-1].
                own_cum_next = mem_rdata;
                mem_addr     = sym_reg - 8'd1;
                state_next   = ST_RD_PREV;
            end
            ST_RD_PREV:
            begin
                prev_next  = (sym_reg == '0) ? '0 : mem_rdata;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
                unique case (act_reg)
                    ACT_UPDATE:
                    begin
                        state_next = ST_UPD_RD;
                    end
                    ACT_ENCODE, ACT_DECODE:
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = hi_reg - lo_reg;
                        div_req.divisor  = 32'(total_reg) + 32'd1;
                        state_next       = ST_DIV;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_UPD_RD:
            begin
                // Decide on first entry; then sweep sym..end.
                if (!pass_reg)
                begin
                    if ((new_total > 34'sd2147483647)
                        || (dlt_reg < 0 && own_plus < 0))
                    begin
                        acc_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        total_next = new_total[COUNT_BITS-1:0];
                        idx_next   = {1'b0, sym_reg};
                        mem_addr   = sym_reg;
                        acc_next   = 1'b1;
                        state_next = ST_UPD_WR;
                    end
                end
                else
                begin
                    mem_addr   = idx_reg[SYM_BITS-1:0];
                    state_next = ST_UPD_WR;
                end
            end
            ST_UPD_WR:
            begin
                // The read of idx issued last cycle is valid now.
                state_next = ST_UPD_RD;
                mem_we     = 1'b1;
                mem_addr   = idx_reg[SYM_BITS-1:0];
                mem_wdata  = mem_rdata + dlt_reg[COUNT_BITS-1:0];
                if (idx_reg == {1'b0, sym_reg})
                    own_cum_next = own_cum_reg + dlt_reg[COUNT_BITS-1:0];
                if (idx_reg == 9'(SYMBOLS - 1))
                    state_next = ST_DONE;
                else
                    idx_next = idx_reg + 9'd1;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    scale_next = div_rsp.quotient;
                    if (act_reg == ACT_ENCODE)
                        state_next = ST_MUL_LO;
                    else
                    begin
                        if (div_rsp.quotient == '0)
                        begin
                            scaled_next = '1;
                            up_next     = 9'(SYMBOLS - 1);
                            low_next    = -10'sd1;
                            state_next  = ST_SEARCH_RD;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = code_reg - lo_reg;
                            div_req.divisor  = div_rsp.quotient;
                            state_next       = ST_DEC_SCALE;
                        end
                    end
                end
            end
            ST_MUL_LO:
            begin
                mul_a      = 32'(prev_reg) + 32'd1;
                lb_next    = lo_reg + mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mul_a = 32'(own_cum_reg) + 32'd1;
                ub_next = lo_reg + mul_p;
                if (own_cum_reg == prev_reg)
                begin
                    lb_next = lo_reg;
                    ub_next = lo_reg + 32'd1;
                end
                state_next = ST_DONE;
            end
            ST_DEC_SCALE:
            begin
                if (div_rsp.done)
                begin
                    scaled_next = div_rsp.quotient;
                    up_next     = 9'(SYMBOLS - 1);
                    low_next    = -10'sd1;
                    state_next  = ST_SEARCH_RD;
                end
            end
            ST_SEARCH_RD:
            begin
                if ($signed({1'b0, up_reg}) > low_reg + 10'sd1)
                begin
                    mem_addr   = mid[SYM_BITS-1:0];
                    idx_next   = mid;
                    state_next = ST_SEARCH_CMP;
                end
                else
                    state_next = ST_DONE;
            end
            ST_SEARCH_CMP:
            begin
                if ({1'b0, mem_rdata} + 32'd1 > scaled_reg)
                    up_next = idx_reg;
                else
                    low_next = $signed({1'b0, idx_reg});
                state_next = ST_SEARCH_RD;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg[SYM_BITS-1:0];
                mem_wdata = '0;
                total_next   = '0;
                own_cum_next = '0;
                prev_next    = '0;
                idx_next     = idx_reg + 9'd1;
                if (idx_reg == 9'(SYMBOLS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                acc_next   = (act_reg == ACT_UPDATE) ? acc_reg : 1'b0;
                olb_next   = (act_reg == ACT_ENCODE) ? lb_reg : '0;
                oub_next   = (act_reg == ACT_ENCODE) ? ub_reg : '0;
                osym_next  = (act_reg == ACT_DECODE) ? up_reg[SYM_BITS-1:0] : '0;
                ocnt_next  = own_cum_reg - prev_reg;
                otot_next  = total_reg;
                oerr_next  = (act_reg == ACT_ENCODE || act_reg == ACT_DECODE)
                             && scale_reg == '0;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            act_reg   <= ACT_CLEAR;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            total_reg <= '0;
            pass_reg  <= 1'b1;
        end
        else
        begin
            // The reset sweep must not produce a result.
            if (state_reg == ST_DONE && pass_reg && act_reg == ACT_CLEAR)
                state_reg <= ST_IDLE;
            else
                state_reg <= state_next;
            act_reg   <= act_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next && !(pass_reg && act_reg == ACT_CLEAR);
            total_reg <= total_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        dlt_reg     <= dlt_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        code_reg    <= code_next;
        own_cum_reg <= own_cum_next;
        prev_reg    <= prev_next;
        scale_reg   <= scale_next;
        scaled_reg  <= scaled_next;
        up_reg      <= up_next;
        low_reg     <= low_next;
        lb_reg      <= lb_next;
        ub_reg      <= ub_next;
        acc_reg     <= acc_next;
        olb_reg     <= olb_next;
        oub_reg     <= oub_next;
        osym_reg    <= osym_next;
        ocnt_reg    <= ocnt_next;
        otot_reg    <= otot_next;
        oerr_reg    <= oerr_next;
    end

    assign busy           = state_reg != ST_IDLE || done_reg;
    assign done           = done_reg;
    assign accepted       = acc_reg;
    assign lower_bound    = olb_reg;
    assign upper_bound    = oub_reg;
    assign decoded_symbol = osym_reg;
    assign symbol_count   = ocnt_reg;
    assign total_count    = otot_reg;
    assign divide_error   = oerr_reg;

    a_busy_while_working: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> busy) else $error("busy low mid request");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held for more than one cycle");
    a_error_only_coding: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_error |-> !accepted) else $error("error on update");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for arith_coder_freq_model.
// Depends on acfm_pkg and the block's RTL; predicts every result from its own count table.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acfm_pkg::*;

    // One request as driven onto the block's input ports.
    typedef struct {
        action_t     act;
        logic [7:0]  sym;
        logic [31:0] dlt;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] code;
    } request_t;

    // One result as seen on the output ports on the done cycle.
    typedef struct packed {
        logic        acc;
        logic [31:0] lb;
        logic [31:0] ub;
        logic [7:0]  dsym;
        logic [30:0] scount;
        logic [30:0] tcount;
        logic        derr;
    } outcome_t;

    // A directed row: the request, and optionally a result typed in by hand.
    typedef struct {
        request_t req;
        bit       typed;
        outcome_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [31:0] delta;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] code_value;
    logic        done;
    logic        accepted;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic [7:0]  decoded_symbol;
    logic [30:0] symbol_count;
    logic [30:0] total_count;
    logic        divide_error;

    // The predictor's copy of the cumulative table and the total.
    logic [30:0] cum_table [SYMBOLS];
    logic [30:0] grand_total;

    outcome_t    pending_results [$];
    int          error_count;

    arith_coder_freq_model dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .symbol         (symbol),
        .delta          (delta),
        .range_low      (range_low),
        .range_high     (range_high),
        .code_value     (code_value),
        .done           (done),
        .accepted       (accepted),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .decoded_symbol (decoded_symbol),
        .symbol_count   (symbol_count),
        .total_count    (total_count),
        .divide_error   (divide_error)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // The count held by one symbol alone, being the difference of neighbours.
    function automatic logic [30:0] own_freq(input logic [7:0] s);
        if (s == 0)
        begin
            return cum_table[0];
        end
        return cum_table[s] - cum_table[s - 1];
    endfunction

    // Applies one request to the predictor's table and returns the result it
    // should cause.
    function automatic outcome_t model_request(input request_t r);
        outcome_t    o;
        logic signed [33:0] new_total;
        logic signed [33:0] own_after;
        logic [31:0] span;
        logic [31:0] scale;
        logic [31:0] prev;
        logic [31:0] scaled;
        int          upper;
        int          lower;
        int          mid;
        o = '{default: '0};
        case (r.act)
            ACT_UPDATE:
            begin
                new_total = $signed({3'b000, grand_total}) + $signed({{2{r.dlt[31]}}, r.dlt});
                own_after = $signed({3'b000, own_freq(r.sym)})
                          + $signed({{2{r.dlt[31]}}, r.dlt});
                // Overflow of the total, or a symbol count driven below zero,
                // leaves the table untouched.
                if (new_total <= 34'sh7FFF_FFFF && !(r.dlt[31] && own_after < 0))
                begin
                    for (int i = r.sym; i < SYMBOLS; i++)
                    begin
                        cum_table[i] = cum_table[i] + r.dlt[30:0];
                    end
                    grand_total = new_total[30:0];
                    o.acc = 1'b1;
                end
            end
            ACT_ENCODE:
            begin
                span  = r.hi - r.lo;
                scale = span / ({1'b0, grand_total} + 32'd1);
                o.derr = (scale == 0);
                prev  = (r.sym == 0) ? 32'd0 : {1'b0, cum_table[r.sym - 1]};
                // A symbol with no count gets the unit range at the bottom.
                if (prev == {1'b0, cum_table[r.sym]})
                begin
                    o.lb = r.lo;
                    o.ub = r.lo + 32'd1;
                end
                else
                begin
                    o.lb = r.lo + (prev + 32'd1) * scale;
                    o.ub = r.lo + ({1'b0, cum_table[r.sym]} + 32'd1) * scale;
                end
            end
            ACT_DECODE:
            begin
                span  = r.hi - r.lo;
                scale = span / ({1'b0, grand_total} + 32'd1);
                if (scale == 0)
                begin
                    o.derr = 1'b1;
                    scaled = '1;
                end
                else
                begin
                    scaled = (r.code - r.lo) / scale;
                end
                upper = SYMBOLS - 1;
                lower = -1;
                while (upper > lower + 1)
                begin
                    mid = (upper + lower) / 2;
                    if ({2'b00, cum_table[mid]} + 33'd1 > {1'b0, scaled})
                    begin
                        upper = mid;
                    end
                    else
                    begin
                        lower = mid;
                    end
                end
                o.dsym = upper[7:0];
            end
            default:
            begin
                for (int i = 0; i < SYMBOLS; i++)
                begin
                    cum_table[i] = '0;
                end
                grand_total = '0;
            end
        endcase
        o.scount = own_freq(r.sym);
        o.tcount = grand_total;
        return o;
    endfunction

    // Issues one request at a falling edge; it is taken at the next rising
    // edge, since busy was seen low in the middle of the cycle.
    task automatic issue_request(input request_t r);
        while (busy)
        begin
            @(negedge clk);
        end
        start      <= 1'b1;
        action     <= r.act;
        symbol     <= r.sym;
        delta      <= r.dlt;
        range_low  <= r.lo;
        range_high <= r.hi;
        code_value <= r.code;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // Random requests of every kind. Updates are mostly small positive amounts that
    // build a realistic table, with a share of large, negative and overflowing ones.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick   = $urandom_range(0, 99);
        r.sym  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        r.lo   = rand_word();
        r.hi   = rand_word();
        r.code = rand_word();
        r.dlt  = rand_word();
        if (pick < 40)
        begin
            r.act = ACT_UPDATE;
            case ($urandom_range(0, 5))
                0, 1, 2: r.dlt = $urandom_range(0, 50);
                3: r.dlt = -$urandom_range(0, 30);
                default: r.dlt = $urandom;
            endcase
        end
        else if (pick < 68)
        begin
            r.act = ACT_ENCODE;
        end
        else if (pick < 97)
        begin
            r.act = ACT_DECODE;
            if ($urandom_range(0, 1))
            begin
                r.lo = $urandom_range(0, 1000);
                r.hi = r.lo + $urandom_range(100000, 32'h7FFF_FFFF);
                r.code = r.lo + $urandom_range(0, r.hi - r.lo);
            end
        end
        else
        begin
            r.act = ACT_CLEAR;
        end
        return r;
    endfunction

    // Compares each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, nothing was requested", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (accepted !== want.acc)
                begin
                    $display("%0t: accepted exp %0h got %0h", $realtime, want.acc, accepted);
                    error_count++;
                end
                if (lower_bound !== want.lb)
                begin
                    $display("%0t: lower_bound exp %0h got %0h", $realtime, want.lb,
                             lower_bound);
                    error_count++;
                end
                if (upper_bound !== want.ub)
                begin
                    $display("%0t: upper_bound exp %0h got %0h", $realtime, want.ub,
                             upper_bound);
                    error_count++;
                end
                if (decoded_symbol !== want.dsym)
                begin
                    $display("%0t: decoded_symbol exp %0h got %0h", $realtime, want.dsym,
                             decoded_symbol);
                    error_count++;
                end
                if (symbol_count !== want.scount)
                begin
                    $display("%0t: symbol_count exp %0h got %0h", $realtime, want.scount,
                             symbol_count);
                    error_count++;
                end
                if (total_count !== want.tcount)
                begin
                    $display("%0t: total_count exp %0h got %0h", $realtime, want.tcount,
                             total_count);
                    error_count++;
                end
                if (divide_error !== want.derr)
                begin
                    $display("%0t: divide_error exp %0h got %0h", $realtime, want.derr,
                             divide_error);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        table_row_t rows [$];
        outcome_t   got;
        request_t   r;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_UPDATE;
        symbol = '0;
        delta = '0;
        range_low = '0;
        range_high = '0;
        code_value = '0;
        error_count = 0;
        for (int i = 0; i < SYMBOLS; i++)
        begin
            cum_table[i] = '0;
        end
        grand_total = '0;

        // Directed table. Typed rows carry results that follow directly from
        // an empty table, a rejected request or a clear.
        rows = '{
            '{'{ACT_ENCODE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd1, 8'd0, 31'd0, 31'd0, 1'b1}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd0, 8'd255, 31'd0, 31'd0, 1'b1}},
            '{'{ACT_UPDATE, 8'd5, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd0, 8'd0, 31'd0, 31'd0, 1'b0}},
            '{'{ACT_UPDATE, 8'd255, 32'h8000_0000, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd0, 8'd0, 31'd0, 31'd0, 1'b0}},
            '{'{ACT_UPDATE, 8'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b1, 32'd0, 32'd0, 8'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0}},
            '{'{ACT_UPDATE, 8'd255, 32'd1, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd0, 8'd0, 31'd0, 31'h7FFF_FFFF, 1'b0}},
            '{'{ACT_ENCODE, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'h0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0,
              '{default: '0}},
            '{'{ACT_CLEAR, 8'd255, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
              '{1'b0, 32'd0, 32'd0, 8'd0, 31'd0, 31'd0, 1'b0}},
            '{'{ACT_UPDATE, 8'd0, 32'd10, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_UPDATE, 8'd128, 32'd20, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_UPDATE, 8'd255, 32'd30, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_UPDATE, 8'd128, 32'hFFFF_FFEB, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_UPDATE, 8'd128, 32'hFFFF_FFEC, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
            '{'{ACT_ENCODE, 8'd0, 32'd0, 32'd100, 32'd10000, 32'd0}, 0, '{default: '0}},
            '{'{ACT_ENCODE, 8'd255, 32'd0, 32'hFFFF_FF00, 32'd5000, 32'd0}, 0, '{default: '0}},
            '{'{ACT_ENCODE, 8'd7, 32'd0, 32'd100, 32'd10000, 32'd0}, 0, '{default: '0}},
            '{'{ACT_ENCODE, 8'd255, 32'd0, 32'd0, 32'd10, 32'd0}, 0, '{default: '0}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd0, 32'd4100, 32'd0}, 0, '{default: '0}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd0, 32'd4100, 32'd1000}, 0, '{default: '0}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd50, 32'd4150, 32'hFFFF_FFFF}, 0, '{default: '0}},
            '{'{ACT_DECODE, 8'd0, 32'd0, 32'd0, 32'd20, 32'd5}, 0, '{default: '0}}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            got = model_request(rows[i].req);
            if (rows[i].typed && got != rows[i].res)
            begin
                $display("%0t: directed row %0d disagrees with its typed result",
                         $realtime, i);
                error_count++;
            end
            pending_results.push_back(rows[i].typed ? rows[i].res : got);
            issue_request(rows[i].req);
            idle_gap();
        end

        for (int n = 0; n < 1700; n++)
        begin
            // Once midway, hold off until every result is home.
            if (n == 850)
            begin
                wait_drained();
            end
            r = random_request();
            pending_results.push_back(model_request(r));
            issue_request(r);
            if ($urandom_range(0, 2) == 0)
            begin
                idle_gap();
            end
        end

        wait_drained();
        repeat (600) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("arith_coder_freq_model regression: pass");
        end
        else
        begin
            $display("arith_coder_freq_model regression: fail");
        end
        $finish;
    end

    // Generous bound: every request as a full-table update with a long gap.
    initial
    begin
        #30000000;
        $display("arith_coder_freq_model regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/acfm_pkg.sv
hw/rtl/acfm_divider.sv
hw/rtl/arith_coder_freq_model.sv
tb/tb.sv
